>>> hw/rtl/plds_pkg.sv
// Shared widths and register codes for the point light diffuse shader.
`timescale 1ns / 1ps
`default_nettype none
package plds_pkg;

	// field widths of the stream items
	localparam int COORD_W    = 11;
	localparam int NORM_W     = 16;
	localparam int LEVEL_W    = 8;
	localparam int IN_W       = 120;
	localparam int OUT_W      = 24;
	localparam int MAX_LIGHTS = 3;
	localparam int CHANNELS   = 3;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int ENABLE_W   = 3;
	localparam int RANGE_W    = 11;
	localparam int COLOR_W    = 24;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_CHANNEL_ENABLE    = 3'd0;
	localparam cfg_idx_t CFG_ATTENUATION_RANGE = 3'd1;
	localparam cfg_idx_t CFG_LIGHT0_COLOR      = 3'd2;
	localparam cfg_idx_t CFG_LIGHT1_COLOR      = 3'd3;
	localparam cfg_idx_t CFG_LIGHT2_COLOR      = 3'd4;

	// datapath widths
	localparam int DIFF_W     = 12;
	localparam int SQ_W       = 24;
	localparam int PROJ_W     = 28;
	localparam int DOT_W      = 30;
	localparam int RAD_W      = 40;
	localparam int LEN_W      = 20;
	localparam int REM_W      = 24;
	localparam int ATT_W      = 22;
	localparam int DEN_W      = 37;
	localparam int PROD_W     = 52;
	localparam int NUM_W      = 61;
	localparam int MAG_W      = 60;
	localparam int QUOT_W     = 31;
	localparam int SHF_W      = DEN_W + QUOT_W;
	localparam int TERM_W     = 32;
	localparam int SUM_W      = 34;

	// pipeline shape: diff, products, sums, root steps, att/den, att*dot,
	// color scale, magnitude, divide steps, signed fix
	localparam int ROOT_STEPS = LEN_W;
	localparam int DEPTH      = 3 + ROOT_STEPS + 4 + QUOT_W + 1;

endpackage
`default_nettype wire

>>> hw/rtl/point_light_diffuse_shader_unit.sv
// Top level of the three point light Lambert diffuse shader pipeline.
//
//  channel | handshake        | payload
//  --------+------------------+---------------------------------------------
//  s_*     | tvalid / tready  | tdata: point, normal and light positions
//  m_*     | tvalid / tready  | tdata: red, green, blue levels
//  cfg_*   | valid / ready    | cfg_index register code, cfg_data value
//
// One item enters per clock while the skid entry is empty. The accepting edge
// loads the first of DEPTH (59) pipeline stages; behind the last stage the
// result passes the output register to m_tvalid. The depth is set by the 20
// root steps and the 31 quotient steps of the per channel dividers.
// Reset clears valid bits and loads the register defaults.
// The whole pipe stalls only when the output register and its skid entry
// are both full; a stall loses and repeats nothing.
`timescale 1ns / 1ps
`default_nettype none
module point_light_diffuse_shader_unit #(
	parameter int LIGHT_COUNT = 3
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// point_x, point_y, normal_x, normal_y, light0_x, light0_y,
	// light1_x, light1_y, light2_x, light2_y
	input  wire logic [plds_pkg::IN_W-1:0]           s_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// red_level, green_level, blue_level
	output logic [plds_pkg::OUT_W-1:0]               m_tdata,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [plds_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [plds_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int QW = plds_pkg::QUOT_W;
	localparam int RS = plds_pkg::ROOT_STEPS;

	// configuration registers
	logic [plds_pkg::ENABLE_W-1:0] chen_q;
	logic [plds_pkg::RANGE_W-1:0]  range_q;
	logic [plds_pkg::COLOR_W-1:0]  color_q [plds_pkg::MAX_LIGHTS];
	logic [plds_pkg::RANGE_W-1:0]  rng;

	assign cfg_ready = 1'b1;
	assign rng = (range_q == '0) ? plds_pkg::RANGE_W'(1) : range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chen_q     <= 3'd7;
			range_q    <= 11'd350;
			color_q[0] <= 24'hFF0000;
			color_q[1] <= 24'h00FF00;
			color_q[2] <= 24'h0000FF;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				plds_pkg::CFG_CHANNEL_ENABLE:    chen_q     <= cfg_data[2:0];
				plds_pkg::CFG_ATTENUATION_RANGE: range_q    <= cfg_data[10:0];
				plds_pkg::CFG_LIGHT0_COLOR:      color_q[0] <= cfg_data;
				plds_pkg::CFG_LIGHT1_COLOR:      color_q[1] <= cfg_data;
				plds_pkg::CFG_LIGHT2_COLOR:      color_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// input field unpacking
	logic signed [plds_pkg::COORD_W-1:0] px, py;
	logic signed [plds_pkg::NORM_W-1:0]  nx, ny;
	logic signed [plds_pkg::COORD_W-1:0] lxin [plds_pkg::MAX_LIGHTS];
	logic signed [plds_pkg::COORD_W-1:0] lyin [plds_pkg::MAX_LIGHTS];

	assign px      = s_tdata[10:0];
	assign py      = s_tdata[21:11];
	assign nx      = s_tdata[37:22];
	assign ny      = s_tdata[53:38];
	assign lxin[0] = s_tdata[64:54];
	assign lyin[0] = s_tdata[75:65];
	assign lxin[1] = s_tdata[86:76];
	assign lyin[1] = s_tdata[97:87];
	assign lxin[2] = s_tdata[108:98];
	assign lyin[2] = s_tdata[119:109];

	// pipeline advance and valid chain
	logic                       en;
	logic                       sk_valid_q;
	logic [plds_pkg::DEPTH-1:0] vld_q;

	assign en       = !sk_valid_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[plds_pkg::DEPTH-2:0], s_tvalid};
		end
	end

	// normal carried to the product stage
	logic signed [plds_pkg::NORM_W-1:0] nx_s1, ny_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1 <= nx;
			ny_s1 <= ny;
		end
	end

	logic signed [plds_pkg::TERM_W-1:0] qf_sf [LIGHT_COUNT][plds_pkg::CHANNELS];

	// one lane per light
	for (genvar l = 0; l < LIGHT_COUNT; l++) begin : g_lane
		logic signed [plds_pkg::DIFF_W-1:0] lx_s1, ly_s1;
		logic signed [plds_pkg::SQ_W-1:0]   lxx_s2, lyy_s2;
		logic signed [plds_pkg::PROJ_W-1:0] lxn_s2, lyn_s2;
		logic [plds_pkg::RAD_W-1:0]         rad_s  [RS+1];
		logic [plds_pkg::LEN_W-1:0]         root_s [RS+1];
		logic [plds_pkg::REM_W-1:0]         rem_s  [RS+1];
		logic signed [plds_pkg::DOT_W-1:0]  dot_s  [RS+1];
		logic signed [plds_pkg::ATT_W-1:0]  att_sa;
		logic [plds_pkg::DEN_W-1:0]         den_sa, den_sb, den_sc;
		logic                               zero_sa, zero_sb, zero_sc;
		logic signed [plds_pkg::DOT_W-1:0]  dot_sa;
		logic signed [plds_pkg::PROD_W-1:0] prod_sb;
		logic signed [plds_pkg::NUM_W-1:0]  num_sc [plds_pkg::CHANNELS];
		logic [plds_pkg::DEN_W-1:0]         dden_s [QW+1];
		logic                               dzero_s [QW+1];
		logic [plds_pkg::MAG_W-1:0]         dn_s   [plds_pkg::CHANNELS][QW+1];
		logic [QW-1:0]                      dq_s   [plds_pkg::CHANNELS][QW+1];
		logic                               dneg_s [plds_pkg::CHANNELS][QW+1];

		// vector to the light, then squares and projections, then their sums
		always_ff @(posedge clk) begin
			if (en) begin
				lx_s1  <= $signed({lxin[l][10], lxin[l]}) - $signed({px[10], px});
				ly_s1  <= $signed({lyin[l][10], lyin[l]}) - $signed({py[10], py});
				lxx_s2 <= lx_s1 * lx_s1;
				lyy_s2 <= ly_s1 * ly_s1;
				lxn_s2 <= lx_s1 * nx_s1;
				lyn_s2 <= ly_s1 * ny_s1;
				rad_s[0]  <= {plds_pkg::SQ_W'(lxx_s2 + lyy_s2), 16'b0};
				root_s[0] <= '0;
				rem_s[0]  <= '0;
				dot_s[0]  <= plds_pkg::DOT_W'(lxn_s2) + plds_pkg::DOT_W'(lyn_s2);
			end
		end

		// length in Q8: one root bit per stage
		for (genvar j = 0; j < RS; j++) begin : g_root
			logic [plds_pkg::REM_W-1:0] rtry, rtrial;

			assign rtry   = {rem_s[j][plds_pkg::REM_W-3:0],
				rad_s[j][plds_pkg::RAD_W-1:plds_pkg::RAD_W-2]};
			assign rtrial = {{(plds_pkg::REM_W-plds_pkg::LEN_W-2){1'b0}}, root_s[j], 2'b01};

			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[j+1] <= {rad_s[j][plds_pkg::RAD_W-3:0], 2'b00};
					dot_s[j+1] <= dot_s[j];
					if (rtry >= rtrial) begin
						rem_s[j+1]  <= rtry - rtrial;
						root_s[j+1] <= {root_s[j][plds_pkg::LEN_W-2:0], 1'b1};
					end else begin
						rem_s[j+1]  <= rtry;
						root_s[j+1] <= {root_s[j][plds_pkg::LEN_W-2:0], 1'b0};
					end
				end
			end
		end

		// attenuation, denominator, then attenuation times dot
		always_ff @(posedge clk) begin
			if (en) begin
				att_sa  <= $signed({3'b000, rng, 8'b0}) - $signed({2'b00, root_s[RS]});
				den_sa  <= {rng, 6'b0} * root_s[RS];
				zero_sa <= (root_s[RS] == '0);
				dot_sa  <= dot_s[RS];
				prod_sb <= att_sa * dot_sa;
				den_sb  <= den_sa;
				zero_sb <= zero_sa;
				den_sc  <= den_sb;
				zero_sc <= zero_sb;
				dden_s[0]  <= den_sc;
				dzero_s[0] <= zero_sc;
			end
		end

		// scale by color byte, split into sign and magnitude
		for (genvar c = 0; c < plds_pkg::CHANNELS; c++) begin : g_chan
			logic [plds_pkg::LEVEL_W-1:0] cbyte;

			assign cbyte = color_q[l][(2-c)*8 +: 8];

			always_ff @(posedge clk) begin
				if (en) begin
					num_sc[c]    <= $signed({1'b0, cbyte}) * prod_sb;
					dneg_s[c][0] <= num_sc[c][plds_pkg::NUM_W-1];
					dn_s[c][0]   <= num_sc[c][plds_pkg::NUM_W-1] ?
						plds_pkg::MAG_W'(-num_sc[c]) : plds_pkg::MAG_W'(num_sc[c]);
					dq_s[c][0]   <= '0;
				end
			end

			// restoring divide, one quotient bit per stage
			for (genvar j = 0; j < QW; j++) begin : g_div
				logic [plds_pkg::SHF_W-1:0] dsh;

				assign dsh = {{QW{1'b0}}, dden_s[j]} << (QW - 1 - j);

				always_ff @(posedge clk) begin
					if (en) begin
						dneg_s[c][j+1] <= dneg_s[c][j];
						if ({{(plds_pkg::SHF_W-plds_pkg::MAG_W){1'b0}}, dn_s[c][j]} >= dsh) begin
							dn_s[c][j+1] <= dn_s[c][j] - dsh[plds_pkg::MAG_W-1:0];
							dq_s[c][j+1] <= {dq_s[c][j][QW-2:0], 1'b1};
						end else begin
							dn_s[c][j+1] <= dn_s[c][j];
							dq_s[c][j+1] <= {dq_s[c][j][QW-2:0], 1'b0};
						end
					end
				end
			end

			// floor for negative quotients, zero for a light on the point
			always_ff @(posedge clk) begin
				if (en) begin
					if (dzero_s[QW])
						qf_sf[l][c] <= '0;
					else if (dneg_s[c][QW])
						qf_sf[l][c] <= -($signed({1'b0, dq_s[c][QW]}) +
							$signed({{(plds_pkg::TERM_W-1){1'b0}}, (dn_s[c][QW] != '0)}));
					else
						qf_sf[l][c] <= $signed({1'b0, dq_s[c][QW]});
				end
			end
		end

		for (genvar j = 0; j < QW; j++) begin : g_dpass
			always_ff @(posedge clk) begin
				if (en) begin
					dden_s[j+1]  <= dden_s[j];
					dzero_s[j+1] <= dzero_s[j];
				end
			end
		end
	end

	// sum over lights, saturate, mask
	logic [plds_pkg::OUT_W-1:0] lvl;

	always_comb begin
		logic signed [plds_pkg::SUM_W-1:0] acc;
		lvl = '0;
		for (int c = 0; c < plds_pkg::CHANNELS; c++) begin
			acc = '0;
			for (int l = 0; l < LIGHT_COUNT; l++)
				acc = acc + plds_pkg::SUM_W'(qf_sf[l][c]);
			if (!chen_q[c] || acc[plds_pkg::SUM_W-1])
				lvl[c*8 +: 8] = '0;
			else if (acc[plds_pkg::SUM_W-1:8] > 255)
				lvl[c*8 +: 8] = 8'hFF;
			else
				lvl[c*8 +: 8] = acc[15:8];
		end
	end

	// output register with one skid entry
	logic                       leave;
	logic [plds_pkg::OUT_W-1:0] sk_data_q;

	assign leave = en && vld_q[plds_pkg::DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid   <= 1'b0;
			sk_valid_q <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			if (sk_valid_q) begin
				m_tvalid   <= 1'b1;
				sk_valid_q <= 1'b0;
			end else begin
				m_tvalid <= leave;
			end
		end else if (leave) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!m_tvalid || m_tready) begin
			if (sk_valid_q)
				m_tdata <= sk_data_q;
			else if (leave)
				m_tdata <= lvl;
		end else if (leave) begin
			sk_data_q <= lvl;
		end
	end

	// checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_valid_q |-> m_tvalid)
		else $error("skid entry held while output register empty");

	a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_valid_q) |-> $past(m_tvalid && !m_tready))
		else $error("skid entry filled without an output stall");

	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && $rose(m_tvalid) && chen_q == '0) |-> m_tdata == '0)
		else $error("disabled channels produced nonzero levels");

endmodule
`default_nettype wire
